@@ rtl/bpms_pkg.sv @@
// bpms_pkg: shared types, constants and helpers of the button press mode sequencer
// no dependencies; used by the interfaces, the button tracker and the top level
package bpms_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEN_W      = 23;
    localparam int unsigned DEB_MS_W   = 10;
    localparam int unsigned DEB_US_W   = 20;
    localparam int unsigned PRESS_W    = 20;
    localparam int unsigned IVL_W      = 31;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [DEB_US_W-1:0] US_PER_MS        = DEB_US_W'(1000);
    localparam logic [DEB_US_W-1:0] DEBOUNCE_US_RST  = DEB_US_W'(50 * 1000);
    localparam logic [PRESS_W-1:0]  LONG_PRESS_RST   = PRESS_W'(5000);
    localparam logic [PRESS_W-1:0]  CONFIG_PRESS_RST = PRESS_W'(10000);
    localparam logic [IVL_W-1:0]    LOG_IVL_RST      = IVL_W'(2000);

    // x / 1000 == (x * DIV1000_MULT) >> DIV1000_SHIFT for any 32-bit x
    localparam int unsigned         DIV1000_SHIFT = 38;
    localparam int unsigned         PROD_W        = 61;
    localparam logic [28:0]         DIV1000_MULT  = 29'd274877907;

    localparam logic [MODE_W-1:0] CODE_STD = 2'd0;
    localparam logic [MODE_W-1:0] CODE_CFG = 2'd1;
    localparam logic [MODE_W-1:0] CODE_MNT = 2'd2;
    localparam logic [MODE_W-1:0] CODE_ECO = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_RED   = 2'd0,
        KIND_GREEN = 2'd1,
        KIND_POLL  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        MODE_STD = 4'b0001,
        MODE_CFG = 4'b0010,
        MODE_MNT = 4'b0100,
        MODE_ECO = 4'b1000
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MODE   = 3'd0,
        REG_DEBOUNCE     = 3'd1,
        REG_LONG_PRESS   = 3'd2,
        REG_CONFIG_PRESS = 3'd3,
        REG_LOG_INTERVAL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             waiting;
        logic [LEN_W-1:0] len_ms;
    } t_btn_status;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_STD: code = CODE_STD;
            MODE_CFG: code = CODE_CFG;
            MODE_MNT: code = CODE_MNT;
            MODE_ECO: code = CODE_ECO;
            default:  code = CODE_STD;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/bpms_if.sv @@
// bpms_if: valid/ready channels of the button press mode sequencer
// depends on bpms_pkg for field widths
interface bpms_in_if;
    logic                            valid;
    logic                            ready;
    logic [bpms_pkg::KIND_W-1:0]     mode;
    logic [bpms_pkg::TIME_W-1:0]     time_us;
    logic [bpms_pkg::TIME_W-1:0]     time_ms;
    logic                            pin_level;

    modport source (output valid, mode, time_us, time_ms, pin_level, input ready);
    modport sink   (input valid, mode, time_us, time_ms, pin_level, output ready);
endinterface

interface bpms_out_if;
    logic                            valid;
    logic                            ready;
    logic [bpms_pkg::MODE_W-1:0]     current_mode;
    logic                            mode_changed;
    logic                            log_to_card;
    logic                            log_to_serial;
    logic                            console_enabled;

    modport source (output valid, current_mode, mode_changed, log_to_card, log_to_serial,
                    console_enabled, input ready);
    modport sink   (input valid, current_mode, mode_changed, log_to_card, log_to_serial,
                    console_enabled, output ready);
endinterface

interface bpms_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bpms_pkg::CFG_IDX_W-1:0]    index;
    logic [bpms_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/button_press_mode_sequencer_top.sv @@
// button_press_mode_sequencer_top: top level of the button press mode sequencer
// depends on bpms_pkg, bpms_if and bpms_button
//
// every input transaction (red edge, green edge, poll or the unused kind code) yields exactly one result
// transaction, registered in the cycle after it is taken; a new transaction can be taken every cycle,
// since all the work is a single pass of compare, subtract and a 32x29 constant multiply
// into the state and result registers; o_out only holds the input back while a result waits
// unread. configuration writes are taken at once, in any cycle; an input transaction
// is held off for a cycle that carries a configuration write.
module button_press_mode_sequencer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpms_in_if.sink      i_in,
    bpms_cfg_if.sink     i_cfg,
    bpms_out_if.source   o_out
);

    typedef struct packed {
        logic [bpms_pkg::MODE_W-1:0] current_mode;
        logic                        mode_changed;
        logic                        log_to_card;
        logic                        log_to_serial;
        logic                        console_enabled;
    } t_result;

    logic [bpms_pkg::DEB_US_W-1:0] r_debounce_us;
    logic [bpms_pkg::PRESS_W-1:0]  r_long_press_ms;
    logic [bpms_pkg::PRESS_W-1:0]  r_config_press_ms;
    logic [bpms_pkg::IVL_W-1:0]    r_log_ivl_ms;

    bpms_pkg::t_mode               r_mode, n_mode;
    bpms_pkg::t_mode               r_mode_before, n_mode_before;
    logic [bpms_pkg::TIME_W-1:0]   r_last_log_ms, n_last_log_ms;

    logic                          r_out_valid;
    t_result                       r_res, n_res;

    bpms_pkg::t_btn_status         w_red, w_green;
    logic                          w_in_acc, w_cfg_acc;
    logic                          w_red_edge, w_green_edge, w_poll;
    logic [bpms_pkg::TIME_W-1:0]   w_log_gap, w_log_ivl;
    logic                          w_red_long, w_red_cfg, w_green_long;

    assign w_in_acc     = i_in.valid && i_in.ready;
    assign w_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign w_red_edge   = w_in_acc && (i_in.mode == bpms_pkg::KIND_RED);
    assign w_green_edge = w_in_acc && (i_in.mode == bpms_pkg::KIND_GREEN);
    assign w_poll       = w_in_acc && (i_in.mode == bpms_pkg::KIND_POLL);

    assign i_in.ready   = (!r_out_valid || o_out.ready) && !i_cfg.valid;
    assign i_cfg.ready  = 1'b1;

    bpms_button u_red (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edge        (w_red_edge),
        .i_clear       (w_poll),
        .i_time_us     (i_in.time_us),
        .i_level       (i_in.pin_level),
        .i_debounce_us (r_debounce_us),
        .o_status      (w_red)
    );

    bpms_button u_green (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edge        (w_green_edge),
        .i_clear       (w_poll),
        .i_time_us     (i_in.time_us),
        .i_level       (i_in.pin_level),
        .i_debounce_us (r_debounce_us),
        .o_status      (w_green)
    );

    assign w_red_long   = w_red.len_ms >= bpms_pkg::LEN_W'(r_long_press_ms);
    assign w_red_cfg    = w_red.len_ms >= bpms_pkg::LEN_W'(r_config_press_ms);
    assign w_green_long = w_green.len_ms >= bpms_pkg::LEN_W'(r_long_press_ms);

    // mode table and log decision, kept only on a poll: red action first, then green on the mode red left behind
    always_comb begin
        n_mode           = r_mode;
        n_mode_before    = r_mode_before;
        n_last_log_ms    = r_last_log_ms;
        n_res            = '0;
        if (w_red.waiting) begin
            unique case (r_mode)
                bpms_pkg::MODE_STD: begin
                    if (w_red_cfg) begin
                        n_mode             = bpms_pkg::MODE_CFG;
                        n_res.mode_changed = 1'b1;
                    end else if (w_red_long) begin
                        n_mode_before      = r_mode;
                        n_mode             = bpms_pkg::MODE_MNT;
                        n_res.mode_changed = 1'b1;
                    end
                end
                bpms_pkg::MODE_CFG: begin
                    if (w_red_long) begin
                        n_mode             = bpms_pkg::MODE_STD;
                        n_res.mode_changed = 1'b1;
                    end
                end
                bpms_pkg::MODE_ECO: begin
                    if (w_red_long) begin
                        n_mode_before      = r_mode;
                        n_mode             = bpms_pkg::MODE_MNT;
                        n_res.mode_changed = 1'b1;
                    end
                end
                bpms_pkg::MODE_MNT: begin
                    if (w_red_long) begin
                        n_mode             = r_mode_before;
                        n_res.mode_changed = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (w_green.waiting) begin
            unique case (n_mode)
                bpms_pkg::MODE_STD: begin
                    if (w_green_long) begin
                        n_mode             = bpms_pkg::MODE_ECO;
                        n_res.mode_changed = 1'b1;
                    end
                end
                bpms_pkg::MODE_MNT: begin
                    if (w_green_long && n_mode_before == bpms_pkg::MODE_ECO) begin
                        n_mode             = bpms_pkg::MODE_ECO;
                        n_res.mode_changed = 1'b1;
                    end
                end
                bpms_pkg::MODE_CFG, bpms_pkg::MODE_ECO: begin
                    if (w_green_long) begin
                        n_mode             = bpms_pkg::MODE_STD;
                        n_res.mode_changed = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        w_log_gap = i_in.time_ms - r_last_log_ms;
        w_log_ivl = (n_mode == bpms_pkg::MODE_ECO) ? {r_log_ivl_ms, 1'b0}
                                                   : {1'b0, r_log_ivl_ms};
        if (n_mode == bpms_pkg::MODE_CFG) begin
            n_res.console_enabled = 1'b1;
        end else if (w_log_gap >= w_log_ivl) begin
            n_last_log_ms       = i_in.time_ms;
            n_res.log_to_serial = 1'b1;
            n_res.log_to_card   = (n_mode != bpms_pkg::MODE_MNT);
        end
        if (!w_poll) begin
            n_mode             = r_mode;
            n_mode_before      = r_mode_before;
            n_last_log_ms      = r_last_log_ms;
            n_res              = '0;
        end
        n_res.current_mode = bpms_pkg::mode_code(n_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_us     <= bpms_pkg::DEBOUNCE_US_RST;
            r_long_press_ms   <= bpms_pkg::LONG_PRESS_RST;
            r_config_press_ms <= bpms_pkg::CONFIG_PRESS_RST;
            r_log_ivl_ms      <= bpms_pkg::LOG_IVL_RST;
            r_mode            <= bpms_pkg::MODE_STD;
            r_mode_before     <= bpms_pkg::MODE_STD;
            r_last_log_ms     <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                unique case (i_cfg.index)
                    bpms_pkg::REG_START_MODE: begin
                        r_mode <= i_cfg.data[0] ? bpms_pkg::MODE_CFG : bpms_pkg::MODE_STD;
                    end
                    bpms_pkg::REG_DEBOUNCE: begin
                        r_debounce_us <= bpms_pkg::DEB_US_W'(i_cfg.data[bpms_pkg::DEB_MS_W-1:0])
                                         * bpms_pkg::US_PER_MS;
                    end
                    bpms_pkg::REG_LONG_PRESS: begin
                        r_long_press_ms <= i_cfg.data[bpms_pkg::PRESS_W-1:0];
                    end
                    bpms_pkg::REG_CONFIG_PRESS: begin
                        r_config_press_ms <= i_cfg.data[bpms_pkg::PRESS_W-1:0];
                    end
                    bpms_pkg::REG_LOG_INTERVAL: begin
                        r_log_ivl_ms <= i_cfg.data[bpms_pkg::IVL_W-1:0];
                    end
                    default: ;
                endcase
            end else begin
                r_mode        <= n_mode;
                r_mode_before <= n_mode_before;
                r_last_log_ms <= n_last_log_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.current_mode    = r_res.current_mode;
    assign o_out.mode_changed    = r_res.mode_changed;
    assign o_out.log_to_card     = r_res.log_to_card;
    assign o_out.log_to_serial   = r_res.log_to_serial;
    assign o_out.console_enabled = r_res.console_enabled;

    a_card_implies_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.log_to_card |-> r_res.log_to_serial)
        else $error("card record without serial record");

    a_console_only_in_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.console_enabled |->
            r_res.current_mode == bpms_pkg::CODE_CFG && !r_res.log_to_serial)
        else $error("console active outside configuration mode");

    a_edge_keeps_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_poll && !w_cfg_acc |=> $stable(r_last_log_ms) && $stable(r_mode))
        else $error("edge transaction changed mode or log time");

    a_poll_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_poll |=> !w_red.waiting && !w_green.waiting)
        else $error("pending press survived a poll");

    a_mnt_before_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_poll && !w_cfg_acc && n_mode == bpms_pkg::MODE_MNT && r_mode != bpms_pkg::MODE_MNT
            |=> r_mode_before == $past(r_mode))
        else $error("earlier mode not kept on entry to maintenance");

endmodule

@@ rtl/bpms_button.sv @@
// bpms_button: debounce and press-length tracking for one push button
// depends on bpms_pkg
module bpms_button (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_edge,
    input  logic                              i_clear,
    input  logic [bpms_pkg::TIME_W-1:0]       i_time_us,
    input  logic                              i_level,
    input  logic [bpms_pkg::DEB_US_W-1:0]     i_debounce_us,
    output bpms_pkg::t_btn_status             o_status
);

    logic [bpms_pkg::TIME_W-1:0] r_last_edge_us, n_last_edge_us;
    logic [bpms_pkg::TIME_W-1:0] r_start_us, n_start_us;
    logic [bpms_pkg::LEN_W-1:0]  r_len_ms, n_len_ms;
    logic                        r_waiting, n_waiting;

    logic [bpms_pkg::TIME_W-1:0] w_gap;
    logic [bpms_pkg::TIME_W-1:0] w_held_us;
    logic [bpms_pkg::PROD_W-1:0] w_prod;
    logic                        w_taken;

    assign w_gap     = i_time_us - r_last_edge_us;
    assign w_taken   = i_edge && (w_gap >= bpms_pkg::TIME_W'(i_debounce_us));
    assign w_held_us = i_time_us - r_start_us;
    assign w_prod    = bpms_pkg::PROD_W'(w_held_us) * bpms_pkg::PROD_W'(bpms_pkg::DIV1000_MULT);

    always_comb begin
        n_last_edge_us = r_last_edge_us;
        n_start_us     = r_start_us;
        n_len_ms       = r_len_ms;
        n_waiting      = r_waiting && !i_clear;
        if (w_taken) begin
            n_last_edge_us = i_time_us;
            if (!i_level) begin
                n_start_us = i_time_us;
            end else if (r_start_us != '0) begin
                n_len_ms   = w_prod[bpms_pkg::DIV1000_SHIFT +: bpms_pkg::LEN_W];
                n_start_us = '0;
                n_waiting  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge_us <= '0;
            r_start_us     <= '0;
            r_len_ms       <= '0;
            r_waiting      <= 1'b0;
        end else begin
            r_last_edge_us <= n_last_edge_us;
            r_start_us     <= n_start_us;
            r_len_ms       <= n_len_ms;
            r_waiting      <= n_waiting;
        end
    end

    assign o_status.waiting = r_waiting;
    assign o_status.len_ms  = r_len_ms;

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for button_press_mode_sequencer_top, directed rows then
// randomised press, poll and noise transactions checked against an in-bench mode predictor
// depends on bpms_pkg, bpms_if and the rtl of the sequencer
`timescale 1ns / 1ps

module testbench;

    localparam logic [bpms_pkg::KIND_W-1:0] KIND_SPARE  = 2'd3;
    localparam int                          QUIET_LIMIT = 3000;
    localparam int                          PHASES      = 7;
    localparam int                          PHASE_ITEMS = 200;

    typedef struct packed {
        logic [bpms_pkg::MODE_W-1:0] current_mode;
        logic                        mode_changed;
        logic                        log_to_card;
        logic                        log_to_serial;
        logic                        console_enabled;
    } t_seq_result;

    typedef struct packed {
        logic [bpms_pkg::KIND_W-1:0] kind;
        logic [31:0]                 us;
        logic [31:0]                 ms;
        logic                        lvl;
        logic                        typed;
        t_seq_result                 want;
    } t_row;

    typedef struct packed {
        logic        start;
        logic [9:0]  debounce;
        logic [19:0] long_ms;
        logic [19:0] config_ms;
        logic [30:0] log_ivl;
    } t_setting;

    localparam t_seq_result NO_TYPED   = '0;
    localparam t_seq_result QUIET_STD  = '{bpms_pkg::CODE_STD, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam t_seq_result LOGGED_STD = '{bpms_pkg::CODE_STD, 1'b0, 1'b1, 1'b1, 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpms_in_if  in_if();
    bpms_cfg_if cfg_if();
    bpms_out_if out_if();

    button_press_mode_sequencer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0]                 btn_last_us  [2] = '{32'd0, 32'd0};
    logic [31:0]                 btn_start_us [2] = '{32'd0, 32'd0};
    logic [bpms_pkg::LEN_W-1:0]  btn_len_ms   [2] = '{23'd0, 23'd0};
    logic                        btn_waiting  [2] = '{1'b0, 1'b0};
    logic [bpms_pkg::MODE_W-1:0] cur_mode         = bpms_pkg::CODE_STD;
    logic [bpms_pkg::MODE_W-1:0] prior_mode       = bpms_pkg::CODE_STD;
    logic [31:0]                 last_log_ms      = 32'd0;
    logic [9:0]                  set_debounce_ms  = 10'd50;
    logic [19:0]                 set_long_ms      = bpms_pkg::LONG_PRESS_RST;
    logic [19:0]                 set_config_ms    = bpms_pkg::CONFIG_PRESS_RST;
    logic [30:0]                 set_log_ivl      = bpms_pkg::LOG_IVL_RST;

    t_seq_result pending_results [$];
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          stall_left  = 0;
    int          stall_odds  = 4;
    int          gap_odds    = 4;
    bit          idle_on     = 1'b1;
    logic [31:0] clock_us    = 32'd100_000_000;
    logic [31:0] clock_ms    = 32'd0;

    t_row directed_rows [27] = '{
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd0,         1'b0, 1'b1, QUIET_STD},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd2000,      1'b0, 1'b1, LOGGED_STD},
        '{bpms_pkg::KIND_RED,   32'd49999,     32'd0,         1'b0, 1'b1, QUIET_STD},
        '{bpms_pkg::KIND_RED,   32'd50000,     32'd0,         1'b0, 1'b1, QUIET_STD},
        '{bpms_pkg::KIND_RED,   32'd10050000,  32'd0,         1'b1, 1'b1, QUIET_STD},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd3000,      1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd100000,    32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd5100000,   32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd3001,      1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd20000000,  32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd25000000,  32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd5000,      1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd40000000,  32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd40000000,  32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd45000000,  32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd46000000,  32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd9000,      1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd0,         32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd20000000,  32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'd10000,     1'b0, 1'b0, NO_TYPED},
        '{KIND_SPARE,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'hFFFF_FFFF, 32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_RED,   32'd9999999,   32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'd0,         32'hFFFF_FFFF, 1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd50000000,  32'd0,         1'b0, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_GREEN, 32'd55000000,  32'd0,         1'b1, 1'b0, NO_TYPED},
        '{bpms_pkg::KIND_POLL,  32'hFFFF_FFFF, 32'd0,         1'b1, 1'b0, NO_TYPED}
    };

    t_setting phase_set [PHASES];

    function automatic logic enter_mode(input logic [bpms_pkg::MODE_W-1:0] m);
        if (m == bpms_pkg::CODE_MNT) prior_mode = cur_mode;
        cur_mode = m;
        return 1'b1;
    endfunction

    function automatic void take_button_edge(input int b, input logic [31:0] now,
                                             input logic lvl);
        logic [31:0] gap;
        gap = now - btn_last_us[b];
        if (gap >= set_debounce_ms * 32'd1000) begin
            btn_last_us[b] = now;
            if (!lvl) begin
                btn_start_us[b] = now;
            end else if (btn_start_us[b] != 32'd0) begin
                btn_len_ms[b]   = bpms_pkg::LEN_W'((now - btn_start_us[b]) / 32'd1000);
                btn_start_us[b] = 32'd0;
                btn_waiting[b]  = 1'b1;
            end
        end
    endfunction

    function automatic t_seq_result advance_sequencer(
        input logic [bpms_pkg::KIND_W-1:0] kind,
        input logic [31:0] us,
        input logic [31:0] ms,
        input logic lvl);
        t_seq_result                r;
        logic                       rp, gp, is_long;
        logic [bpms_pkg::LEN_W-1:0] rd, gd;
        logic [32:0]                span;
        r = '0;
        case (kind)
            bpms_pkg::KIND_RED:   take_button_edge(0, us, lvl);
            bpms_pkg::KIND_GREEN: take_button_edge(1, us, lvl);
            bpms_pkg::KIND_POLL: begin
                rp = btn_waiting[0];
                gp = btn_waiting[1];
                rd = btn_len_ms[0];
                gd = btn_len_ms[1];
                btn_waiting[0] = 1'b0;
                btn_waiting[1] = 1'b0;
                if (rp) begin
                    is_long = rd >= set_long_ms;
                    case (cur_mode)
                        bpms_pkg::CODE_STD: begin
                            if (rd >= set_config_ms)
                                r.mode_changed = enter_mode(bpms_pkg::CODE_CFG);
                            else if (is_long)
                                r.mode_changed = enter_mode(bpms_pkg::CODE_MNT);
                        end
                        bpms_pkg::CODE_CFG:
                            if (is_long) r.mode_changed = enter_mode(bpms_pkg::CODE_STD);
                        bpms_pkg::CODE_ECO:
                            if (is_long) r.mode_changed = enter_mode(bpms_pkg::CODE_MNT);
                        default:
                            if (is_long) r.mode_changed = enter_mode(prior_mode);
                    endcase
                end
                if (gp) begin
                    is_long = gd >= set_long_ms;
                    case (cur_mode)
                        bpms_pkg::CODE_STD:
                            if (is_long) r.mode_changed = enter_mode(bpms_pkg::CODE_ECO);
                        bpms_pkg::CODE_CFG:
                            if (is_long) r.mode_changed = enter_mode(bpms_pkg::CODE_STD);
                        bpms_pkg::CODE_MNT: begin
                            if (is_long && prior_mode == bpms_pkg::CODE_ECO)
                                r.mode_changed = enter_mode(bpms_pkg::CODE_ECO);
                        end
                        default:
                            if (is_long) r.mode_changed = enter_mode(bpms_pkg::CODE_STD);
                    endcase
                end
                // economy logs at twice the interval
                span = (cur_mode == bpms_pkg::CODE_ECO) ? {1'b0, set_log_ivl, 1'b0}
                                                        : {2'b00, set_log_ivl};
                if (cur_mode == bpms_pkg::CODE_CFG) begin
                    r.console_enabled = 1'b1;
                end else if ({1'b0, ms - last_log_ms} >= span) begin
                    last_log_ms     = ms;
                    r.log_to_serial = 1'b1;
                    r.log_to_card   = (cur_mode != bpms_pkg::CODE_MNT);
                end
            end
            default: ;
        endcase
        r.current_mode = cur_mode;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_event(input logic [bpms_pkg::KIND_W-1:0] kind, input logic [31:0] us,
                              input logic [31:0] ms, input logic lvl, input logic typed,
                              input t_seq_result want);
        t_seq_result predicted;
        if (idle_on && $urandom_range(0, gap_odds) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= kind;
        in_if.time_us   <= us;
        in_if.time_ms   <= ms;
        in_if.pin_level <= lvl;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = advance_sequencer(kind, us, ms, lvl);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic press_button(input logic [bpms_pkg::KIND_W-1:0] kind);
        longint deb_us;
        longint hold_ms;
        deb_us = longint'(set_debounce_ms) * 1000;
        // now and then land inside the debounce window
        if ($urandom_range(0, 7) == 0) clock_us += 32'($urandom_range(0, int'(deb_us)));
        else clock_us += 32'(deb_us + $urandom_range(1, 3000));
        send_event(kind, clock_us, $urandom, 1'b0, 1'b0, NO_TYPED);
        case ($urandom_range(0, 7))
            0:       hold_ms = longint'(set_long_ms) - 1;
            1:       hold_ms = longint'(set_long_ms);
            2:       hold_ms = longint'(set_config_ms) - 1;
            3:       hold_ms = longint'(set_config_ms);
            4:       hold_ms = longint'($urandom_range(0, set_long_ms));
            5:       hold_ms = longint'(set_config_ms) + longint'($urandom_range(0, 100));
            6:       hold_ms = longint'($urandom_range(0, 20));
            default: hold_ms = longint'(set_long_ms)
                               + longint'($urandom_range(0, set_long_ms / 2 + 1));
        endcase
        if (hold_ms < 0) hold_ms = 0;
        clock_us += 32'(hold_ms * 1000 + longint'($urandom_range(0, 999)));
        send_event(kind, clock_us, $urandom, 1'b1, 1'b0, NO_TYPED);
    endtask

    task automatic poll_now();
        longint span;
        span = (cur_mode == bpms_pkg::CODE_ECO) ? 2 * longint'(set_log_ivl)
                                                : longint'(set_log_ivl);
        case ($urandom_range(0, 6))
            0:       clock_ms += 32'(span - 1);
            1:       clock_ms += 32'(span);
            2:       clock_ms += 32'(span + 1);
            3:       clock_ms += 32'(span / 2);
            4:       clock_ms += 32'($urandom_range(0, 10));
            5:       clock_ms += $urandom;
            default: clock_ms += 32'($urandom_range(0, 3000));
        endcase
        send_event(bpms_pkg::KIND_POLL, $urandom, clock_ms, 1'($urandom), 1'b0, NO_TYPED);
    endtask

    task automatic apply_settings(input t_setting s);
        bpms_pkg::t_reg_idx idx;
        logic [30:0]        val;
        idx = idx.first();
        do begin
            case (idx)
                bpms_pkg::REG_START_MODE:   val = 31'(s.start);
                bpms_pkg::REG_DEBOUNCE:     val = 31'(s.debounce);
                bpms_pkg::REG_LONG_PRESS:   val = 31'(s.long_ms);
                bpms_pkg::REG_CONFIG_PRESS: val = 31'(s.config_ms);
                default:                    val = s.log_ivl;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= val;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_if.valid    <= 1'b0;
        set_debounce_ms = s.debounce;
        set_long_ms     = s.long_ms;
        set_config_ms   = s.config_ms;
        set_log_ivl     = s.log_ivl;
        // writing the start mode loads the current mode straight away
        cur_mode        = s.start ? bpms_pkg::CODE_CFG : bpms_pkg::CODE_STD;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (idle_on && stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, stall_odds) == 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 17);
        end else begin
            out_if.ready <= 1'b1;
            stall_left   <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_seq_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result transaction with none expected, mode",
                              32'(out_if.current_mode), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.current_mode !== want.current_mode)
                    flag_mismatch("current_mode", 32'(out_if.current_mode),
                                  32'(want.current_mode));
                if (out_if.mode_changed !== want.mode_changed)
                    flag_mismatch("mode_changed", 32'(out_if.mode_changed),
                                  32'(want.mode_changed));
                if (out_if.log_to_card !== want.log_to_card)
                    flag_mismatch("log_to_card", 32'(out_if.log_to_card),
                                  32'(want.log_to_card));
                if (out_if.log_to_serial !== want.log_to_serial)
                    flag_mismatch("log_to_serial", 32'(out_if.log_to_serial),
                                  32'(want.log_to_serial));
                if (out_if.console_enabled !== want.console_enabled)
                    flag_mismatch("console_enabled", 32'(out_if.console_enabled),
                                  32'(want.console_enabled));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int count;
        int pick;
        int sel;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.mode      <= bpms_pkg::KIND_RED;
        in_if.time_us   <= 32'd0;
        in_if.time_ms   <= 32'd0;
        in_if.pin_level <= 1'b1;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= bpms_pkg::REG_START_MODE;
        cfg_if.data     <= '0;

        phase_set[0] = '{1'b1, 10'd50,   20'd5000,   20'd10000,  31'd2000};
        phase_set[1] = '{1'b0, 10'd0,    20'd0,      20'd0,      31'd0};
        phase_set[2] = '{1'b0, 10'd1000, 20'd600000, 20'd600000, 31'h7FFF_FFFF};
        phase_set[3] = '{1'b1, 10'd3,    20'd20,     20'd40,     31'd10};
        phase_set[4] = '{1'b0, 10'd10,   20'd100,    20'd50,     31'd100};
        phase_set[5] = '{1'($urandom), 10'($urandom_range(0, 1000)),
                         20'($urandom_range(0, 600000)), 20'($urandom_range(0, 600000)),
                         31'($urandom_range(0, 5000))};
        phase_set[6] = '{1'b0, 10'd1,    20'd30,     20'd60,     31'd50};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_event(directed_rows[i].kind, directed_rows[i].us, directed_rows[i].ms,
                       directed_rows[i].lvl, directed_rows[i].typed, directed_rows[i].want);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            // the closing phase runs flat out on both sides
            idle_on    = (p != PHASES - 1);
            gap_odds   = (p % 3 == 0) ? 2 : 8;
            stall_odds = (p % 2 == 0) ? 3 : 10;
            apply_settings(phase_set[p]);
            count = 0;
            while (count < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    sel = $urandom_range(0, 2);
                    if (sel != 1) press_button(bpms_pkg::KIND_RED);
                    if (sel != 0) press_button(bpms_pkg::KIND_GREEN);
                    poll_now();
                    count += (sel == 2) ? 5 : 3;
                end else if (pick < 75) begin
                    poll_now();
                    count++;
                end else if (pick < 90) begin
                    sel = $urandom_range(1, 3);
                    repeat (sel)
                        send_event($urandom_range(0, 1) ? bpms_pkg::KIND_GREEN
                                                        : bpms_pkg::KIND_RED,
                                   $urandom_range(0, 1) ? $urandom
                                       : clock_us + $urandom_range(0, set_debounce_ms * 1000 + 10),
                                   $urandom, 1'($urandom), 1'b0, NO_TYPED);
                    count += sel;
                end else if (pick < 95) begin
                    send_event(KIND_SPARE, $urandom, $urandom, 1'($urandom), 1'b0, NO_TYPED);
                    count++;
                end else begin
                    clock_us += $urandom;
                    clock_ms += $urandom;
                    poll_now();
                    count++;
                end
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
